[rtl/core/bgd_pkg.sv]
// Shared types and constants of the button gesture detector.
// Holds the scan and gesture payload structs, the configuration bundle,
// event codes and configuration register indexes. No dependencies.
package bgd_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TIME       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TIME     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_CLICK_WINDOW = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_INTERVAL     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED             = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] DEBOUNCE_TIME_RESET       = 16'd20;
  localparam logic [15:0] LONG_PRESS_TIME_RESET     = 16'd1000;
  localparam logic [15:0] DOUBLE_CLICK_WINDOW_RESET = 16'd300;
  localparam logic [15:0] REPEAT_INTERVAL_RESET     = 16'd300;

  // Event codes reported on the gesture channel.
  localparam logic [2:0] EV_DOUBLE  = 3'd0;
  localparam logic [2:0] EV_LONG    = 3'd1;
  localparam logic [2:0] EV_REPEAT  = 3'd2;
  localparam logic [2:0] EV_RELEASE = 3'd3;
  localparam logic [2:0] EV_CLICK   = 3'd4;

  typedef struct packed {
    logic        pressed;
    logic [31:0] now_ms;
  } scan_t;

  typedef struct packed {
    logic [2:0]  event_code;
    logic [31:0] held_ms;
    logic [1:0]  click_tally;
    logic [7:0]  repeat_tally;
  } gesture_t;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [15:0] long_press_time;
    logic [15:0] double_click_window;
    logic [15:0] repeat_interval;
    logic        enabled;
  } cfg_t;

endpackage

[rtl/core/button_gesture_detector.sv]
// Top level of the button gesture detector: scan input register, configuration
// registers and the gesture state machine. Depends on bgd_pkg and bgd_fsm.
//
// Usage. Each request on the scan channel (scan_valid, scan_stall, scan_data)
// is one sample of the key: its level and a millisecond timestamp. Each
// request on the gesture channel (gesture_valid, gesture_stall, gesture_data)
// reports one event: double click, long press release, repeat, release after
// repeat or click, with the press duration and the click and repeat counts.
// Most scans report nothing; a scan reports at most one event.
// A scan that is taken sits in the input register; once it advances, the state
// machine updates and the event, if any, is loaded into the result register.
// One scan is taken every cycle as long as the result register is empty or
// being emptied; the single state update per scan sets that rate. When the
// receiver stalls with an event waiting, the input register holds its scan and
// scan_stall rises until the event is taken.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// taken; cfg_index selects debounce time, long press time, double click window,
// repeat interval or enable, and other indexes are ignored. Writing 0 to the
// enable returns the machine to idle. A synchronous reset restores the default
// timings, enables the block and clears all gesture state and both channels.
module button_gesture_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                scan_valid,
  output logic                                scan_stall,
  input  bgd_pkg::scan_t                      scan_data,
  output logic                                gesture_valid,
  input  logic                                gesture_stall,
  output bgd_pkg::gesture_t                   gesture_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bgd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bgd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bgd_pkg::cfg_t  cfg;
  bgd_pkg::scan_t scan_held;
  logic           scan_held_valid;
  logic           advance;
  logic           cfg_write;
  logic           clear;

  // The configuration port never back-pressures.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign clear     = cfg_write && (cfg_index == bgd_pkg::CFG_ENABLED) && !cfg_data[0];

  // The held scan moves on whenever the result register can take its outcome.
  assign advance    = scan_held_valid && (!gesture_valid || !gesture_stall);
  assign scan_stall = scan_held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time       <= bgd_pkg::DEBOUNCE_TIME_RESET;
      cfg.long_press_time     <= bgd_pkg::LONG_PRESS_TIME_RESET;
      cfg.double_click_window <= bgd_pkg::DOUBLE_CLICK_WINDOW_RESET;
      cfg.repeat_interval     <= bgd_pkg::REPEAT_INTERVAL_RESET;
      cfg.enabled             <= 1'b1;
      scan_held_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          bgd_pkg::CFG_DEBOUNCE_TIME:       cfg.debounce_time       <= cfg_data;
          bgd_pkg::CFG_LONG_PRESS_TIME:     cfg.long_press_time     <= cfg_data;
          bgd_pkg::CFG_DOUBLE_CLICK_WINDOW: cfg.double_click_window <= cfg_data;
          bgd_pkg::CFG_REPEAT_INTERVAL:     cfg.repeat_interval     <= cfg_data;
          bgd_pkg::CFG_ENABLED:             cfg.enabled             <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (!scan_held_valid || advance) begin
        scan_held_valid <= scan_valid;
      end
      if (scan_valid && !scan_stall) begin
        scan_held <= scan_data;
      end
    end
  end

  bgd_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .clear         (clear),
    .step          (advance),
    .scan          (scan_held),
    .gesture_valid (gesture_valid),
    .gesture_data  (gesture_data),
    .gesture_stall (gesture_stall)
  );

endmodule

[rtl/core/bgd_fsm.sv]
// Gesture state machine of the button gesture detector with its result register.
// Depends on bgd_pkg for the scan, gesture and configuration types.
module bgd_fsm (
  input  logic            clk,
  input  logic            rst,
  input  bgd_pkg::cfg_t   cfg,
  input  logic            clear,
  input  logic            step,
  input  bgd_pkg::scan_t  scan,
  output logic            gesture_valid,
  output bgd_pkg::gesture_t gesture_data,
  input  logic            gesture_stall
);

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DEBOUNCE = 3'd1,
    ST_PRESSED  = 3'd2,
    ST_LONG     = 3'd3,
    ST_RELEASED = 3'd4
  } state_t;

  state_t      state, state_next;
  logic [31:0] press_start, press_start_next;
  logic [1:0]  clicks_seen, clicks_next;
  logic [7:0]  repeats_seen, repeats_next;
  logic        repeat_happened, repeat_happened_next;
  logic        double_happened, double_happened_next;

  logic        ev_emit;
  logic [2:0]  ev_code;
  logic [1:0]  ev_clicks;
  logic [7:0]  ev_repeats;

  logic [31:0] elapsed;
  logic [23:0] repeat_offset;
  logic [31:0] repeat_limit;

  assign elapsed       = scan.now_ms - press_start;
  assign repeat_offset = repeats_seen * cfg.repeat_interval;
  assign repeat_limit  = {16'd0, cfg.long_press_time} + {8'd0, repeat_offset};

  always_comb begin
    state_next           = state;
    press_start_next     = press_start;
    clicks_next          = clicks_seen;
    repeats_next         = repeats_seen;
    repeat_happened_next = repeat_happened;
    double_happened_next = double_happened;
    ev_emit              = 1'b0;
    ev_code              = bgd_pkg::EV_CLICK;
    ev_clicks            = clicks_seen;
    ev_repeats           = repeats_seen;
    if (cfg.enabled) begin
      unique case (state)
        ST_IDLE: begin
          if (scan.pressed) begin
            state_next       = ST_DEBOUNCE;
            press_start_next = scan.now_ms;
            clicks_next      = 2'd0;
          end
        end
        ST_DEBOUNCE: begin
          if (!scan.pressed) begin
            state_next  = ST_IDLE;
            clicks_next = 2'd0;
          end else if (elapsed >= {16'd0, cfg.debounce_time}) begin
            state_next = ST_PRESSED;
            if (clicks_seen == 2'd2) begin
              clicks_next          = 2'd0;
              double_happened_next = 1'b1;
              ev_emit              = 1'b1;
              ev_code              = bgd_pkg::EV_DOUBLE;
              ev_clicks            = 2'd0;
            end else begin
              clicks_next = 2'd1;
            end
          end
        end
        ST_PRESSED: begin
          if (!scan.pressed) begin
            state_next = ST_RELEASED;
          end else if (elapsed >= {16'd0, cfg.long_press_time}) begin
            state_next   = ST_LONG;
            repeats_next = 8'd1;
          end
        end
        ST_LONG: begin
          if (!scan.pressed) begin
            state_next = ST_IDLE;
            ev_emit    = 1'b1;
            if (repeat_happened) begin
              repeat_happened_next = 1'b0;
              ev_code              = bgd_pkg::EV_RELEASE;
            end else begin
              ev_code     = bgd_pkg::EV_LONG;
              clicks_next = 2'd0;
            end
          end else if (elapsed >= repeat_limit) begin
            if (repeats_seen != 8'hFF) begin
              repeats_next = repeats_seen + 8'd1;
            end
            repeat_happened_next = 1'b1;
            ev_emit              = 1'b1;
            ev_code              = bgd_pkg::EV_REPEAT;
            ev_repeats           = repeats_next;
          end
        end
        ST_RELEASED: begin
          if (scan.pressed) begin
            state_next       = ST_DEBOUNCE;
            clicks_next      = (elapsed < {16'd0, cfg.double_click_window}) ? 2'd2 : 2'd0;
            press_start_next = scan.now_ms;
          end else if (elapsed >= {16'd0, cfg.double_click_window}) begin
            state_next  = ST_IDLE;
            clicks_next = 2'd0;
            if (double_happened) begin
              double_happened_next = 1'b0;
            end else begin
              ev_emit   = 1'b1;
              ev_code   = bgd_pkg::EV_CLICK;
              ev_clicks = 2'd0;
            end
          end
        end
        default: begin
          // Codes outside the five states fall back to idle.
          state_next  = ST_IDLE;
          clicks_next = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      press_start     <= 32'd0;
      clicks_seen     <= 2'd0;
      repeats_seen    <= 8'd0;
      repeat_happened <= 1'b0;
      double_happened <= 1'b0;
      gesture_valid   <= 1'b0;
    end else begin
      if (clear) begin
        state        <= ST_IDLE;
        clicks_seen  <= 2'd0;
        repeats_seen <= 8'd0;
      end else if (step) begin
        state           <= state_next;
        press_start     <= press_start_next;
        clicks_seen     <= clicks_next;
        repeats_seen    <= repeats_next;
        repeat_happened <= repeat_happened_next;
        double_happened <= double_happened_next;
      end
      if (!gesture_valid || !gesture_stall) begin
        gesture_valid <= step && ev_emit;
      end
      if (step && ev_emit) begin
        gesture_data.event_code   <= ev_code;
        gesture_data.held_ms      <= elapsed;
        gesture_data.click_tally  <= ev_clicks;
        gesture_data.repeat_tally <= ev_repeats;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A disable write always leaves the machine idle with no clicks counted.
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clear |=> (state == ST_IDLE && clicks_seen == 2'd0))
    else $error("bgd_fsm: disable did not return the machine to idle");

  // The click counter only ever holds zero, one or two.
  a_clicks_range: assert property (@(posedge clk) disable iff (rst)
    clicks_seen != 2'd3)
    else $error("bgd_fsm: click counter out of range");

  // While a long press is held the repeat counter has been started.
  a_long_repeats: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LONG) |-> (repeats_seen != 8'd0))
    else $error("bgd_fsm: long press state with zero repeat count");

  // A double click moves the machine to pressed with the counter cleared.
  a_double_next: assert property (@(posedge clk) disable iff (rst)
    (step && !clear && ev_emit && ev_code == bgd_pkg::EV_DOUBLE)
      |=> (state == ST_PRESSED && clicks_seen == 2'd0 && double_happened))
    else $error("bgd_fsm: double click did not enter pressed state");
`endif

endmodule
